/* sv/csb_pkg.sv */
// shared types and constants of the cross stencil blur filter
package csb_pkg;

   // field and register widths
   localparam int PIXEL_W      = 8;
   localparam int SUM_W        = 11;
   localparam int ROW_W        = 12;
   localparam int HEIGHT_W     = 13;
   localparam int WIDTH_REG_W  = 11;
   localparam int DIST_REG_W   = 4;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   // frame limits and parameter defaults
   localparam int MAX_HEIGHT        = 4096;
   localparam int DEF_MAX_WIDTH     = 1024;
   localparam int DEF_MAX_BLUR_DIST = 8;

   // register reset values
   localparam logic [WIDTH_REG_W-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [HEIGHT_W-1:0]    RESET_HEIGHT = 13'd480;
   localparam logic [DIST_REG_W-1:0]  RESET_DIST   = 4'd8;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   // divide by five: floor(sum * 3277 / 2^14) is exact for sums up to 1275
   localparam int RECIP_W     = 12;
   localparam logic [RECIP_W-1:0] RECIP_FIVE = 12'd3277;
   localparam int RECIP_SHIFT = 14;

   // one pending result: five-point sum and end-of-frame mark
   typedef struct packed {
      logic             frame_last;
      logic [SUM_W-1:0] sum;
   } csb_entry_type;

endpackage

/* sv/cross_stencil_blur.sv */
// top level of the cross stencil blur filter
// Five-point cross mean filter over an 8-bit grayscale image streamed in raster order, one
// pixel per request. Each interior pixel (at least blur_distance from every edge) yields
// floor((center + up + down + left + right) / 5), emitted when the pixel blur_distance rows
// below the center arrives; rsp_tlast marks the last result of a frame, border pixels give
// nothing. The block takes one pixel per clock for as long as responses are drained;
// req_tready is set by the four-entry result queue plus the registered line store read.
// The result of a triggering pixel passes the line store read register, the queue and the
// divide register before rsp_tvalid rises. The line store is two copies of
// 2*MAX_BLUR_DIST rows of MAX_WIDTH bytes with no clearing after reset, so the first frame
// after reset or after a geometry change must be a complete frame. Registers (index 0 width,
// 1 height, 2 distance) must be written by the user only between frames; not enforced.
module cross_stencil_blur #(
   parameter int MAX_WIDTH     = csb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_BLUR_DIST = csb_pkg::DEF_MAX_BLUR_DIST
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [csb_pkg::PIXEL_W-1:0]       req_tdata,   // [7:0] pixel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [csb_pkg::PIXEL_W-1:0]       rsp_tdata,   // [7:0] blurred
   output logic                              rsp_tlast,   // frame_last
   input  logic                              csr_we,
   input  logic [csb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [csb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import csb_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int DW = $clog2(MAX_BLUR_DIST + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_BLUR_DISTANCE = 2'd2
   } csr_index_type;

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0]     height_ff, height_in;
   logic [DIST_REG_W-1:0]   dist_ff, dist_in;
   logic [WW-1:0]           width_eff;
   logic [HEIGHT_W-1:0]     height_eff;
   logic [DW-1:0]           dist_eff;

   logic                    push, pop, head_valid;
   csb_entry_type           push_entry, head_entry;
   logic [LEVEL_W-1:0]      q_level;

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      dist_in   = dist_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:   width_in  = csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT:  height_in = csr_wdata[HEIGHT_W-1:0];
            CSR_BLUR_DISTANCE: dist_in   = csr_wdata[DIST_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         dist_ff   <= RESET_DIST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         dist_ff   <= dist_in;
      end
   end

   // clamp register values to the supported range
   assign width_eff  = (width_ff == '0) ? WW'(1)
                     : (32'(width_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_ff);
   assign height_eff = (height_ff == '0) ? HEIGHT_W'(1)
                     : (32'(height_ff) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT) : height_ff;
   assign dist_eff   = (32'(dist_ff) > MAX_BLUR_DIST) ? DW'(MAX_BLUR_DIST) : DW'(dist_ff);

   csb_front #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_BLUR_DIST (MAX_BLUR_DIST)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .dist_eff   (dist_eff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_level    (q_level),
      .push       (push),
      .push_entry (push_entry)
   );

   csb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .level      (q_level)
   );

   csb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* sv/csb_front.sv */
// front end: raster counters, interior test, line store and five-point sum
module csb_front #(
   parameter int MAX_WIDTH     = csb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_BLUR_DIST = csb_pkg::DEF_MAX_BLUR_DIST
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]       width_eff,
   input  logic [csb_pkg::HEIGHT_W-1:0]         height_eff,
   input  logic [$clog2(MAX_BLUR_DIST+1)-1:0]   dist_eff,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [csb_pkg::PIXEL_W-1:0]          req_tdata,   // [7:0] pixel
   input  logic [csb_pkg::LEVEL_W-1:0]          q_level,
   output logic                                 push,
   output csb_pkg::csb_entry_type               push_entry
);
   import csb_pkg::*;

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int STORE_ROWS = 2 * MAX_BLUR_DIST;
   localparam int SRW        = $clog2(STORE_ROWS);
   localparam int RX         = SRW + 1;
   localparam int XW         = ((WW > HEIGHT_W) ? WW : HEIGHT_W) + 1;

   logic              accept;
   logic [CW-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SRW-1:0]    prow_ff, prow_in;
   logic [XW-1:0]     w_x, h_x, d_x, d2_x, r_x, c_x;
   logic              hit, last, dzero, row_end, frame_end;
   logic [RX-1:0]     ctr_sum, top_sum;
   logic [SRW-1:0]    ctr_row, top_row;
   logic [CW-1:0]     col_l, col_r;

   // two copies of the line store so each sees one write and two reads
   logic [PIXEL_W-1:0] mem_a [STORE_ROWS][MAX_WIDTH];
   logic [PIXEL_W-1:0] mem_b [STORE_ROWS][MAX_WIDTH];

   logic [PIXEL_W-1:0] rd_ctr_ff, rd_top_ff, rd_lft_ff, rd_rgt_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_hit_ff, s1_last_ff, s1_dzero_ff;
   logic [PIXEL_W-1:0] s1_px_ff;
   logic [SUM_W-1:0]   sum;

   // room for the request in the read stage plus a new one
   assign req_tready = ((LEVEL_W+1)'(q_level) + (LEVEL_W+1)'(s1_valid_ff))
                       < (LEVEL_W+1)'(QUEUE_DEPTH);
   assign accept = req_tvalid && req_tready;

   // common compare width
   assign w_x  = XW'(width_eff);
   assign h_x  = XW'(height_eff);
   assign d_x  = XW'(dist_eff);
   assign d2_x = d_x << 1;
   assign r_x  = XW'(row_ff);
   assign c_x  = XW'(col_ff);

   // interior test and end-of-frame mark
   assign hit = (h_x > d2_x) && (w_x > d2_x) && (r_x < h_x) && (c_x < w_x)
                && (r_x >= d2_x) && (c_x >= d_x) && (c_x + d_x < w_x);
   assign last  = (r_x + XW'(1) == h_x) && (c_x + d_x + XW'(1) == w_x);
   assign dzero = (dist_eff == '0);

   // raster counters and store row pointer (row modulo store rows)
   assign row_end   = (c_x + XW'(1) >= w_x);
   assign frame_end = (r_x + XW'(1) >= h_x);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      prow_in = prow_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            if (frame_end) begin
               row_in  = '0;
               prow_in = '0;
            end else begin
               row_in  = row_ff + ROW_W'(1);
               prow_in = (prow_ff == SRW'(STORE_ROWS - 1)) ? '0 : prow_ff + SRW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         prow_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         prow_ff <= prow_in;
      end
   end

   // store rows of the center row and the row two distances up
   assign ctr_sum = RX'(prow_ff) + RX'(STORE_ROWS) - RX'(dist_eff);
   assign top_sum = RX'(prow_ff) + RX'(STORE_ROWS) - (RX'(dist_eff) << 1);
   assign ctr_row = (ctr_sum >= RX'(STORE_ROWS)) ? SRW'(ctr_sum - RX'(STORE_ROWS))
                                                 : SRW'(ctr_sum);
   assign top_row = (top_sum >= RX'(STORE_ROWS)) ? SRW'(top_sum - RX'(STORE_ROWS))
                                                 : SRW'(top_sum);
   assign col_l = col_ff - CW'(dist_eff);
   assign col_r = col_ff + CW'(dist_eff);

   // line store: read old contents, then write the new pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_a[prow_ff][col_ff] <= req_tdata;
         mem_b[prow_ff][col_ff] <= req_tdata;
         rd_ctr_ff <= mem_a[ctr_row][col_ff];
         rd_top_ff <= mem_a[top_row][col_ff];
         rd_lft_ff <= mem_b[ctr_row][col_l];
         rd_rgt_ff <= mem_b[ctr_row][col_r];
      end
   end

   // read stage control
   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hit_ff   <= hit;
         s1_last_ff  <= last;
         s1_dzero_ff <= dzero;
         s1_px_ff    <= req_tdata;
      end
   end

   // five-point sum; with zero distance every tap is the center pixel
   always_comb begin
      if (s1_dzero_ff) begin
         sum = (SUM_W'(s1_px_ff) << 2) + SUM_W'(s1_px_ff);
      end else begin
         sum = SUM_W'(rd_ctr_ff) + SUM_W'(rd_top_ff) + SUM_W'(rd_lft_ff)
               + SUM_W'(rd_rgt_ff) + SUM_W'(s1_px_ff);
      end
   end

   assign push                  = s1_valid_ff && s1_hit_ff;
   assign push_entry.sum        = sum;
   assign push_entry.frame_last = s1_last_ff;

endmodule

/* sv/csb_queue.sv */
// short queue of pending sums between front and back
module csb_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  csb_pkg::csb_entry_type        push_entry,
   input  logic                          pop,
   output logic                          head_valid,
   output csb_pkg::csb_entry_type        head_entry,
   output logic [csb_pkg::LEVEL_W-1:0]   level
);
   import csb_pkg::*;

   csb_entry_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0]  count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + LEVEL_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign level      = count_ff;

endmodule

/* sv/csb_back.sv */
// back end: divide the sum by five into the response register
module csb_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  csb_pkg::csb_entry_type            head_entry,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [csb_pkg::PIXEL_W-1:0]       rsp_tdata,   // [7:0] blurred
   output logic                              rsp_tlast    // frame_last
);
   import csb_pkg::*;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]         rsp_data_ff;
   logic                       rsp_last_ff;
   logic [SUM_W+RECIP_W-1:0]   prod;

   // take the head when the response register is free or being drained
   assign pop = head_valid && (!rsp_valid_ff || rsp_tready);

   // floor divide by five through the reciprocal
   assign prod = (SUM_W+RECIP_W)'(head_entry.sum) * (SUM_W+RECIP_W)'(RECIP_FIVE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= prod[RECIP_SHIFT +: PIXEL_W];
         rsp_last_ff <= head_entry.frame_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
